// ===== hdl/tdf_pkg.sv =====
package tdf_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_START  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_CHECK  = 4'b1000
    } tdf_state_t;

    // Status returned by the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== hdl/tdf_divider.sv =====
module tdf_divider
    import tdf_pkg::*;
#(
    parameter int WIDTH = 31
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder,
    output div_status_t      status
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;

    // One restoring step per cycle: shift in the next dividend bit and
    // subtract the divisor when it fits.
    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[WIDTH]) begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== hdl/trial_division_factorizer.sv =====
// Trial-division prime factorizer. Each input word carries one unsigned
// integer; the block returns its prime factors in ascending order, repeated
// by multiplicity, with m_last_factor set on the final one. Inputs 0 and 1
// return nothing. One item is handled at a time: s_ready is high only while
// the sequencer is idle. Every trial divisor runs a start state,
// VALUE_WIDTH steps of the restoring divider, a wait for its done
// flag and a check state. An item takes up to sqrt(value) trials
// plus one repeated trial for each factor found, and the check state
// also waits on m_ready to free the output register. There is no reset
// sweep.
module trial_division_factorizer
    import tdf_pkg::*;
#(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_prime_factor,
    output logic                   m_last_factor
);

    tdf_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_factor_reg, out_factor_next;
    logic                   out_last_reg, out_last_next;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [VALUE_WIDTH-1:0] div_rem;
    div_status_t            div_st;

    logic                   found;
    logic                   past_root;
    logic                   out_free;

    tdf_divider #(
        .WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (q_reg),
        .divisor   (d_reg),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_st)
    );

    // The divisor is a factor when the remainder is zero; the search ends
    // once the divisor exceeds the quotient, i.e. its square exceeds q.
    assign found     = (div_rem == '0);
    assign past_root = (d_reg > div_quot);
    assign out_free  = !out_valid_reg || m_ready;
    assign div_start = (state_reg == ST_START);

    // Sequencer and output word register.
    always_comb begin
        state_next      = state_reg;
        q_next          = q_reg;
        d_next          = d_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_factor_next = out_factor_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    q_next = s_value_in;
                    d_next = VALUE_WIDTH'(2);
                    if (s_value_in > VALUE_WIDTH'(1)) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_st.done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (found || past_root) begin
                    // A factor is ready; wait until the output register frees.
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        if (found) begin
                            out_factor_next = d_reg;
                            out_last_next   = (div_quot == VALUE_WIDTH'(1));
                            q_next          = div_quot;
                            state_next      = (div_quot == VALUE_WIDTH'(1)) ? ST_IDLE
                                                                            : ST_START;
                        end else begin
                            out_factor_next = q_reg;
                            out_last_next   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                end else begin
                    d_next     = d_reg + VALUE_WIDTH'(1);
                    state_next = ST_START;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        q_reg          <= q_next;
        d_reg          <= d_next;
        out_factor_reg <= out_factor_next;
        out_last_reg   <= out_last_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_prime_factor = out_factor_reg;
    assign m_last_factor  = out_last_reg;

    // A reported factor is never below two.
    a_factor_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_prime_factor >= VALUE_WIDTH'(2)))
        else $error("factor below two on output");

    // The divider only finishes while the sequencer waits for it.
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    // A division never runs with a divisor below two.
    a_divisor_min: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (d_reg >= VALUE_WIDTH'(2)))
        else $error("divider started with divisor below two");

    // A new division is only started once the previous one has finished.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_st.busy)
        else $error("divider started while still busy");

endmodule

// ===== sim/tdf_factor_checker.sv =====
module tdf_factor_checker #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value_in,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [VALUE_WIDTH-1:0] m_prime_factor,
    input  logic                   m_last_factor,
    output int                     error_count,
    output int                     pending,
    output int                     values_seen,
    output int                     factors_seen,
    output int                     longest_burst
);
    timeunit 1ns;
    timeprecision 1ps;

    // Factors still owed by the block, oldest first, with their end-of-value marks.
    logic [VALUE_WIDTH-1:0] want_factor [$];
    bit                     want_last [$];

    int errors_n   = 0;
    int values_n   = 0;
    int factors_n  = 0;
    int longest_n  = 0;
    int burst;

    logic [63:0]            quot;
    logic [63:0]            trial;
    logic [VALUE_WIDTH-1:0] exp_factor;
    bit                     exp_last;

    // Only the first few failures are printed; the rest are counted.
    task automatic flag_error(input string msg);
        errors_n++;
        if (errors_n <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Queue one owed factor behind those already waiting.
    task automatic owe_factor(input logic [VALUE_WIDTH-1:0] factor, input bit is_last);
        want_factor = {want_factor, factor};
        want_last   = {want_last, is_last};
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            // Compare each returned word with the oldest factor still owed.
            if (m_valid && m_ready) begin
                factors_n++;
                if (want_factor.size() == 0) begin
                    flag_error($sformatf("unexpected factor word: got %0d last %0b",
                                         m_prime_factor, m_last_factor));
                end else begin
                    exp_factor = want_factor.pop_front();
                    exp_last   = want_last.pop_front();
                    if (m_prime_factor !== exp_factor || m_last_factor !== exp_last) begin
                        flag_error($sformatf(
                            "factor mismatch: expected %0d last %0b, got %0d last %0b",
                            exp_factor, exp_last, m_prime_factor, m_last_factor));
                    end
                end
            end

            // Factor each accepted value by trial division. The square test is
            // done as a division so it stays exact at any width. The final
            // factor is marked either when the quotient drops to one or when
            // a cofactor above one remains after the trials.
            if (s_valid && s_ready) begin
                values_n++;
                quot  = 64'(s_value_in);
                burst = 0;
                if (quot >= 2) begin
                    for (trial = 2; trial <= quot / trial; trial++) begin
                        while (quot % trial == 0) begin
                            quot = quot / trial;
                            owe_factor(trial[VALUE_WIDTH-1:0], quot == 1);
                            burst++;
                        end
                    end
                    if (quot > 1) begin
                        owe_factor(quot[VALUE_WIDTH-1:0], 1'b1);
                        burst++;
                    end
                end
                if (burst > longest_n) begin
                    longest_n = burst;
                end
            end
        end

        error_count   <= errors_n;
        pending       <= want_factor.size();
        values_seen   <= values_n;
        factors_seen  <= factors_n;
        longest_burst <= longest_n;
    end

endmodule

// ===== sim/trial_division_factorizer_test.sv =====
module trial_division_factorizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          VALUE_WIDTH      = 31;
    localparam longint      VALUE_MAX        = (64'd1 << VALUE_WIDTH) - 1;
    localparam int          RANDOM_ITEMS     = 100;
    localparam int          QUIET_TAIL       = 20;
    localparam int          HOLD_AT_ITEM     = 30;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          TIMEOUT_NS       = 100_000_000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [VALUE_WIDTH-1:0] s_value_in;
    logic                   m_valid;
    logic                   m_ready;
    logic [VALUE_WIDTH-1:0] m_prime_factor;
    logic                   m_last_factor;

    int error_count;
    int pending;
    int values_seen;
    int factors_seen;
    int longest_burst;

    bit idling_on     = 1'b1;
    bit long_hold_req = 1'b0;

    // Corner values: zero and one, small primes and prime powers, a prime
    // square, larger primes, thirty-factor values ending either way, and
    // bit patterns that drive every bit of the value both ways.
    logic [VALUE_WIDTH-1:0] corner_values [21] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd6, 31'd8, 31'd9, 31'd12, 31'd25,
        31'd30, 31'd15015, 31'd65521, 31'd994009, 31'd1000003,
        31'd1073741824, 31'd1610612736, 31'd2147483646, 31'd1431655765,
        31'd715827882, 31'd1162261467
    };

    trial_division_factorizer #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value_in    (s_value_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_factor(m_prime_factor),
        .m_last_factor (m_last_factor)
    );

    tdf_factor_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value_in    (s_value_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_factor(m_prime_factor),
        .m_last_factor (m_last_factor),
        .error_count   (error_count),
        .pending       (pending),
        .values_seen   (values_seen),
        .factors_seen  (factors_seen),
        .longest_burst (longest_burst)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Reset is held low from the start and released on a falling edge.
    initial begin
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Hard stop in case the block hangs or loses a factor.
    initial begin
        #TIMEOUT_NS;
        $display("trial_division_factorizer_test: errors");
        $finish;
    end

    // Random values are mostly products of small and medium factors, so the
    // trial count stays low while the value still reaches the top bits.
    // A bounded cofactor may add one factor up to 40000, and some values are
    // shifted up to set the top bit. A few are raw small values or 0 and 1.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        longint      acc;
        int unsigned f;
        int unsigned mode;
        int unsigned draw;
        int          count;
        int          reps;
        mode = $urandom_range(0, 99);
        if (mode < 4) begin
            return VALUE_WIDTH'($urandom_range(0, 1));
        end
        if (mode < 14) begin
            return VALUE_WIDTH'($urandom_range(2, 70000));
        end
        acc   = 1;
        count = $urandom_range(1, 10);
        for (int k = 0; k < count; k++) begin
            draw = $urandom_range(0, 99);
            if (draw < 80) begin
                f = $urandom_range(2, 60);
            end else if (draw < 95) begin
                f = $urandom_range(61, 400);
            end else begin
                f = $urandom_range(401, 1500);
            end
            reps = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
            repeat (reps) begin
                if (acc * f <= VALUE_MAX) begin
                    acc = acc * f;
                end
            end
        end
        if ($urandom_range(0, 9) < 4 && acc * 40000 <= VALUE_MAX) begin
            acc = acc * $urandom_range(2, 40000);
        end
        if ($urandom_range(0, 9) < 3) begin
            while (acc * 2 <= VALUE_MAX) begin
                acc = acc * 2;
            end
        end
        return acc[VALUE_WIDTH-1:0];
    endfunction

    // Offer one value, after an optional idle burst, and wait for acceptance.
    task automatic push_value(input logic [VALUE_WIDTH-1:0] value);
        int gap;
        gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid    <= 1'b0;
            s_value_in <= VALUE_WIDTH'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_value_in <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge aclk);
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat ($urandom_range(0, 24)) @(negedge aclk);
        end
    end

    // Input side: corner values, a full drain, then random values.
    initial begin
        s_valid    = 1'b0;
        s_value_in = '0;
        wait (aresetn === 1'b1);

        foreach (corner_values[k]) begin
            push_value(corner_values[k]);
        end

        // Hold the input off until every owed factor has been returned.
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS - QUIET_TAIL) begin
                idling_on = 1'b0;
            end
            // A cheap value with several factors, then keep offering words
            // while the result side is held off, so the input stalls.
            if (k == HOLD_AT_ITEM) begin
                long_hold_req = 1'b1;
                push_value(31'd15015);
            end
            push_value(pick_value());
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge aclk);

        $display("Factored %0d values into %0d prime factor words.",
                 values_seen, factors_seen);
        $display("Longest factor run from one value: %0d words; mismatches: %0d.",
                 longest_burst, error_count);
        if (error_count == 0) begin
            $display("trial_division_factorizer_test: clean");
        end else begin
            $display("trial_division_factorizer_test: errors");
        end
        $finish;
    end

endmodule
